// ===== hw/rtl/ptpd_pkg.sv =====
package ptpd_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CoordW   = 32;
  localparam int unsigned MagW     = 64;
  localparam int unsigned SumW     = 66;
  localparam int unsigned QuoBits  = 33;
  localparam int unsigned DivLat   = QuoBits + 1;
  localparam int unsigned FrontLat = 4;

  localparam logic [CoordW-1:0] PosMax = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] NegMax = 32'h8000_0000;

  typedef logic [CfgDataW-1:0] cfg_word_t;

endpackage

// ===== hw/rtl/ptpd_div_lane.sv =====
module ptpd_div_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [ptpd_pkg::MagW-1:0]        num_i,
  input  logic [ptpd_pkg::MagW-1:0]        den_i,
  input  logic                             neg_i,
  output logic [ptpd_pkg::CoordW-1:0]      quo_o,
  output logic                             clip_o
);

  localparam int unsigned NW = ptpd_pkg::MagW + FRAC_BITS;
  localparam int unsigned QB = ptpd_pkg::QuoBits;
  localparam int unsigned CW = NW + QB;

  logic [NW-1:0]       r_q   [QB+1];
  logic [QB-1:0]       q_q   [QB+1];
  logic [CW-1:0]       d_q   [QB+1];
  logic                ov_q  [QB+1];
  logic                neg_q [QB+1];

  logic [CW-1:0] den_ext;
  logic [CW-1:0] num_ext;
  logic          ov_d;

  assign den_ext = {{(CW-ptpd_pkg::MagW){1'b0}}, den_i};
  assign num_ext = {{QB{1'b0}}, num_i, {FRAC_BITS{1'b0}}};
  assign ov_d    = num_ext >= (den_ext << QB);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= num_ext[NW-1:0];
      q_q[0]   <= '0;
      d_q[0]   <= den_ext;
      ov_q[0]  <= ov_d;
      neg_q[0] <= neg_i;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [CW-1:0] sh;
    logic          ge;
    logic [NW-1:0] r_d;

    assign sh  = d_q[k-1] << (QB - k);
    assign ge  = {{QB{1'b0}}, r_q[k-1]} >= sh;
    assign r_d = ge ? (r_q[k-1] - sh[NW-1:0]) : r_q[k-1];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]   <= r_d;
        q_q[k]   <= {q_q[k-1][QB-2:0], ge};
        d_q[k]   <= d_q[k-1];
        ov_q[k]  <= ov_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  logic [QB-1:0] q_fin;
  logic [QB-1:0] q_neg;

  assign q_fin = q_q[QB];
  assign q_neg = (~q_fin) + QB'(1);

  always_comb begin
    if (!neg_q[QB]) begin
      if (ov_q[QB] || (q_fin > {1'b0, ptpd_pkg::PosMax})) begin
        quo_o  = ptpd_pkg::PosMax;
        clip_o = 1'b1;
      end else begin
        quo_o  = q_fin[ptpd_pkg::CoordW-1:0];
        clip_o = 1'b0;
      end
    end else begin
      if (ov_q[QB] || (q_fin > {1'b0, ptpd_pkg::NegMax})) begin
        quo_o  = ptpd_pkg::NegMax;
        clip_o = 1'b1;
      end else begin
        quo_o  = q_neg[ptpd_pkg::CoordW-1:0];
        clip_o = 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/point_transform_perspective_divide_core.sv =====
// Point transform with perspective divide, signed fixed point.
// s_axis carries one point (x, y, z) per request; it is multiplied as the row
// vector [x y z 1] by the 4x4 matrix in the configuration registers, and
// X, Y, Z are divided by W. m_axis returns the three quotients and two flags.
// The cfg channel writes one 64-bit matrix register per request; it is always
// ready, and indexes 8 and above are dropped. Write it only while idle.
// A point passes through the input register, products, sums and magnitudes,
// the restoring divider (an entry register, then one quotient bit per stage,
// three lanes in parallel), and the output register to reach m_axis.
// Throughput is one point per cycle while m_axis does not stall.
// Reset loads the identity matrix and empties the pipeline.
// When m_axis stalls with a result held, the whole pipeline holds and
// s_axis_tready drops in the same cycle; nothing is lost or repeated.
// W equal to zero gives zero outputs with w_is_zero set and clipped clear.
module point_transform_perspective_divide_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // tdata: pos_x [31:0], pos_y [63:32], pos_z [95:64]
  input  logic [95:0]                     s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: out_x [31:0], out_y [63:32], out_z [95:64]
  output logic [95:0]                     m_axis_tdata,
  // tuser: w_is_zero [0], clipped [1]
  output logic [1:0]                      m_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ptpd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [ptpd_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned SW  = ptpd_pkg::SumW;
  localparam int unsigned VL  = ptpd_pkg::FrontLat + ptpd_pkg::DivLat;
  localparam int unsigned DL  = ptpd_pkg::DivLat;

  ptpd_pkg::cfg_word_t cfg_q [ptpd_pkg::NumRegs];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ptpd_pkg::NumRegs; i++) begin
        cfg_q[i] <= '0;
      end
      cfg_q[0] <= 64'(1) << FRAC_BITS;
      cfg_q[2] <= 64'(1) << (FRAC_BITS + 32);
      cfg_q[5] <= 64'(1) << FRAC_BITS;
      cfg_q[7] <= 64'(1) << (FRAC_BITS + 32);
    end else if (cfg_valid_i && (cfg_index_i < ptpd_pkg::CfgIdxW'(ptpd_pkg::NumRegs))) begin
      cfg_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  logic signed [31:0] m [4][4];

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = cfg_q[r*2 + c/2][(c%2)*32 +: 32];
      end
    end
  end

  logic en;
  logic [VL-1:0] v_q;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[VL-2:0], s_axis_tvalid};
    end
  end

  logic signed [31:0] p_q    [3];
  logic signed [63:0] prod_q [3][4];
  logic signed [SW-1:0] sum_q [4];
  logic [ptpd_pkg::MagW-1:0] mag_q [4];
  logic neg_q [4];
  logic wz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= s_axis_tdata[31:0];
      p_q[1] <= s_axis_tdata[63:32];
      p_q[2] <= s_axis_tdata[95:64];
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 4; c++) begin
          prod_q[k][c] <= p_q[k] * m[k][c];
        end
      end
      for (int c = 0; c < 4; c++) begin
        sum_q[c] <= SW'(prod_q[0][c]) + SW'(prod_q[1][c]) + SW'(prod_q[2][c])
                  + (SW'(m[3][c]) <<< FRAC_BITS);
      end
    end
  end

  logic [SW-1:0] abs_d [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      abs_d[c] = sum_q[c][SW-1] ? -sum_q[c] : sum_q[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        mag_q[c] <= abs_d[c][ptpd_pkg::MagW-1:0];
        neg_q[c] <= sum_q[c][SW-1];
      end
      wz_q <= abs_d[3][ptpd_pkg::MagW-1:0] == '0;
    end
  end

  logic [DL-1:0] wzl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      wzl_q <= {wzl_q[DL-2:0], wz_q};
    end
  end

  logic [31:0] quo  [3];
  logic        clip [3];

  for (genvar c = 0; c < 3; c++) begin : g_lane
    ptpd_div_lane #(
      .FRAC_BITS (FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .num_i  (mag_q[c]),
      .den_i  (mag_q[3]),
      .neg_i  (neg_q[c] ^ neg_q[3]),
      .quo_o  (quo[c]),
      .clip_o (clip[c])
    );
  end

  logic        out_valid_q;
  logic [95:0] out_data_q;
  logic [1:0]  out_user_q;
  logic        wz_fin;

  assign wz_fin = wzl_q[DL-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_q[VL-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= wz_fin ? '0 : {quo[2], quo[1], quo[0]};
      out_user_q <= {!wz_fin && (clip[0] || clip[1] || clip[2]), wz_fin};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  a_wz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1] && (m_axis_tdata == '0))
    else $error("w_is_zero result with nonzero data or clip");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready disagrees with output stall");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[VL-1] && en |=> m_axis_tvalid)
    else $error("result at pipeline end did not reach output");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("pipeline moved during stall");

endmodule
